// File: rtl/bpj_pkg.sv
// bpj_pkg: shared types, constants and register codes of the depth pixel
// back-projection core
// no dependencies
`default_nettype none

package bpj_pkg;

  // field widths
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned DEPTH_W   = 16;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned OUT_W     = 24;
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned RAY_W     = IDX_W + DEPTH_W;      // col*d, row*d
  localparam int unsigned PROD_W    = COEF_W + RAY_W + 1;   // signed product
  localparam int unsigned PSUM_W    = PROD_W + 1;
  localparam int unsigned ACC_W     = PROD_W + 3;
  localparam int unsigned CFG_IDX_W = 3;

  // default image bound
  localparam int unsigned MAX_DIMENSION_DEF = 4096;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_K_00    = 3'd0,
    REG_INV_K_01    = 3'd1,
    REG_INV_K_02    = 3'd2,
    REG_INV_K_11    = 3'd3,
    REG_INV_K_12    = 3'd4,
    REG_INV_K_22    = 3'd5,
    REG_MIN_DEPTH   = 3'd6,
    REG_MAX_DEPTH   = 3'd7
  } cfg_reg_t;

  // configuration register file contents
  typedef struct packed {
    logic signed [COEF_W-1:0]  k00;
    logic signed [COEF_W-1:0]  k01;
    logic signed [COEF_W-1:0]  k02;
    logic signed [COEF_W-1:0]  k11;
    logic signed [COEF_W-1:0]  k12;
    logic signed [COEF_W-1:0]  k22;
    logic        [DEPTH_W-1:0] depth_lo;
    logic        [DEPTH_W-1:0] depth_hi;
  } cfg_t;

  // input pixel
  typedef struct packed {
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [DEPTH_W-1:0] d;
    logic               present;
  } pix_t;

  // after ray stage
  typedef struct packed {
    logic               ok;
    logic [DEPTH_W-1:0] d;
    logic [RAY_W-1:0]   cd;
    logic [RAY_W-1:0]   rd;
  } ray_t;

  // after multiply stage
  typedef struct packed {
    logic                     ok;
    logic signed [PROD_W-1:0] p00;
    logic signed [PROD_W-1:0] p01;
    logic signed [PROD_W-1:0] p02;
    logic signed [PROD_W-1:0] p11;
    logic signed [PROD_W-1:0] p12;
    logic signed [PROD_W-1:0] p22;
  } prod_t;

  // after partial sums
  typedef struct packed {
    logic                     ok;
    logic signed [PSUM_W-1:0] xa;
    logic signed [PSUM_W-1:0] xb;
    logic signed [PSUM_W-1:0] ya;
    logic signed [PSUM_W-1:0] yb;
    logic signed [PSUM_W-1:0] za;
  } psum_t;

  // full sums, rounding offset included
  typedef struct packed {
    logic                    ok;
    logic signed [ACC_W-1:0] ax;
    logic signed [ACC_W-1:0] ay;
    logic signed [ACC_W-1:0] az;
  } acc_t;

  // result point
  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic                    valid;
  } point_t;

endpackage

`default_nettype wire

// File: rtl/bpj_ray_stage.sv
// bpj_ray_stage: validity check and ray terms col*d, row*d
// depends on bpj_pkg
`default_nettype none

module bpj_ray_stage
  import bpj_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire pix_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output ray_t      out_data
);

  logic valid_r;
  ray_t data_r;
  ray_t data_nxt;

  // stage moves when empty or when downstream takes its item
  assign in_ready = !valid_r || out_ready;

  // range checks and the two small products
  always_comb begin
    data_nxt.ok = in_data.present &&
                  (in_data.d >= cfg.depth_lo) && (in_data.d <= cfg.depth_hi) &&
                  (32'(in_data.row) < 32'(MAX_DIMENSION)) &&
                  (32'(in_data.col) < 32'(MAX_DIMENSION));
    data_nxt.d  = in_data.d;
    data_nxt.cd = RAY_W'(in_data.col) * RAY_W'(in_data.d);
    data_nxt.rd = RAY_W'(in_data.row) * RAY_W'(in_data.d);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

// File: rtl/bpj_mult_stage.sv
// bpj_mult_stage: the six coefficient products of the inverse intrinsic matrix
// depends on bpj_pkg
`default_nettype none

module bpj_mult_stage
  import bpj_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire ray_t  in_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output prod_t      out_data
);

  logic  valid_r;
  prod_t data_r;
  prod_t data_nxt;

  logic signed [PROD_W-1:0] cd_s;
  logic signed [PROD_W-1:0] rd_s;
  logic signed [PROD_W-1:0] d_s;

  assign in_ready = !valid_r || out_ready;

  // zero-extended ray terms as signed operands
  assign cd_s = $signed(PROD_W'(in_data.cd));
  assign rd_s = $signed(PROD_W'(in_data.rd));
  assign d_s  = $signed(PROD_W'(in_data.d));

  // one 32 x 29 multiplier per coefficient
  always_comb begin
    data_nxt.ok  = in_data.ok;
    data_nxt.p00 = PROD_W'(PROD_W'(cfg.k00) * cd_s);
    data_nxt.p01 = PROD_W'(PROD_W'(cfg.k01) * rd_s);
    data_nxt.p02 = PROD_W'(PROD_W'(cfg.k02) * d_s);
    data_nxt.p11 = PROD_W'(PROD_W'(cfg.k11) * rd_s);
    data_nxt.p12 = PROD_W'(PROD_W'(cfg.k12) * d_s);
    data_nxt.p22 = PROD_W'(PROD_W'(cfg.k22) * d_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

// File: rtl/bpj_accum_stage.sv
// bpj_accum_stage: two register stages that add the products and the
// rounding offset; depends on bpj_pkg
`default_nettype none

module bpj_accum_stage
  import bpj_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire prod_t in_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output acc_t       out_data
);

  localparam logic signed [PSUM_W-1:0] RND = PSUM_W'(1) <<< (FRAC_BITS - 1);

  logic  ps_valid_r;
  psum_t ps_r;
  psum_t ps_nxt;
  logic  ps_ready;
  logic  ps_move;
  logic  acc_valid_r;
  acc_t  acc_r;
  acc_t  acc_nxt;

  // first stage: pairwise sums, rounding offset folded in
  assign ps_ready = !ps_valid_r || ps_move;
  assign ps_move  = !acc_valid_r || out_ready;
  assign in_ready = ps_ready;

  always_comb begin
    ps_nxt.ok = in_data.ok;
    ps_nxt.xa = PSUM_W'(in_data.p00) + PSUM_W'(in_data.p01);
    ps_nxt.xb = PSUM_W'(in_data.p02) + RND;
    ps_nxt.ya = PSUM_W'(in_data.p11);
    ps_nxt.yb = PSUM_W'(in_data.p12) + RND;
    ps_nxt.za = PSUM_W'(in_data.p22) + RND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_valid_r <= 1'b0;
    end else if (ps_ready) begin
      ps_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ps_ready && in_valid) begin
      ps_r <= ps_nxt;
    end
  end

  // second stage: final sums
  always_comb begin
    acc_nxt.ok = ps_r.ok;
    acc_nxt.ax = ACC_W'(ps_r.xa) + ACC_W'(ps_r.xb);
    acc_nxt.ay = ACC_W'(ps_r.ya) + ACC_W'(ps_r.yb);
    acc_nxt.az = ACC_W'(ps_r.za);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_valid_r <= 1'b0;
    end else if (ps_move) begin
      acc_valid_r <= ps_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ps_move && ps_valid_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign out_valid = acc_valid_r;
  assign out_data  = acc_r;

endmodule

`default_nettype wire

// File: rtl/bpj_sat_stage.sv
// bpj_sat_stage: scale by 2^-24, saturate to 24 bits, zero skipped points;
// holds the output register; depends on bpj_pkg
`default_nettype none

module bpj_sat_stage
  import bpj_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire acc_t   in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output point_t      out_data
);

  localparam int unsigned Q_W = ACC_W - FRAC_BITS;
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-(64'sd1 <<< (OUT_W - 1)));

  logic   valid_r;
  point_t data_r;
  point_t data_nxt;

  // floor shift then clamp
  function automatic logic signed [OUT_W-1:0] scale_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [Q_W-1:0] q;
    q = Q_W'(acc >>> FRAC_BITS);
    if (q > Q_MAX) begin
      return OUT_W'(Q_MAX);
    end else if (q < Q_MIN) begin
      return OUT_W'(Q_MIN);
    end
    return OUT_W'(q);
  endfunction

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    data_nxt.valid = in_data.ok;
    data_nxt.x     = in_data.ok ? scale_sat(in_data.ax) : '0;
    data_nxt.y     = in_data.ok ? scale_sat(in_data.ay) : '0;
    data_nxt.z     = in_data.ok ? scale_sat(in_data.az) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

// File: rtl/depth_pixel_backprojection_core.sv
// depth_pixel_backprojection_core: pinhole back-projection of depth pixels.
// Pipeline: five register stages
// (ray terms, multiply, two adder stages, scale and saturate with output register).
// Throughput: one pixel per cycle; each stage holds its item under stall.
// Reset: synchronous active-low rst_n empties the pipeline and loads the
// identity matrix with full depth range into the configuration registers.
`default_nettype none

module depth_pixel_backprojection_core
  import bpj_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [COEF_W-1:0]     cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [IDX_W-1:0]      in_pixel_row,
  input  wire logic [IDX_W-1:0]      in_pixel_col,
  input  wire logic [DEPTH_W-1:0]    in_depth_mm,
  input  wire logic                  in_depth_present,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [OUT_W-1:0]    out_point_x,
  output logic signed [OUT_W-1:0]    out_point_y,
  output logic signed [OUT_W-1:0]    out_point_z,
  output logic                       out_point_valid
);

  localparam logic signed [COEF_W-1:0] ONE = COEF_W'(1) <<< FRAC_BITS;

  cfg_t   cfg_r;
  pix_t   pix;
  ray_t   ray;
  prod_t  prod;
  acc_t   acc;
  point_t pt;
  logic   ray_valid;
  logic   ray_ready;
  logic   prod_valid;
  logic   prod_ready;
  logic   acc_valid;
  logic   acc_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.k00      <= ONE;
      cfg_r.k01      <= '0;
      cfg_r.k02      <= '0;
      cfg_r.k11      <= ONE;
      cfg_r.k12      <= '0;
      cfg_r.k22      <= ONE;
      cfg_r.depth_lo <= '0;
      cfg_r.depth_hi <= '1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_INV_K_00:  cfg_r.k00      <= $signed(cfg_wdata);
        REG_INV_K_01:  cfg_r.k01      <= $signed(cfg_wdata);
        REG_INV_K_02:  cfg_r.k02      <= $signed(cfg_wdata);
        REG_INV_K_11:  cfg_r.k11      <= $signed(cfg_wdata);
        REG_INV_K_12:  cfg_r.k12      <= $signed(cfg_wdata);
        REG_INV_K_22:  cfg_r.k22      <= $signed(cfg_wdata);
        REG_MIN_DEPTH: cfg_r.depth_lo <= cfg_wdata[DEPTH_W-1:0];
        REG_MAX_DEPTH: cfg_r.depth_hi <= cfg_wdata[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // input pixel
  assign pix.row     = in_pixel_row;
  assign pix.col     = in_pixel_col;
  assign pix.d       = in_depth_mm;
  assign pix.present = in_depth_present;

  // pipeline
  bpj_ray_stage #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_ray (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (pix),
    .out_valid(ray_valid),
    .out_ready(ray_ready),
    .out_data (ray)
  );

  bpj_mult_stage u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (ray_valid),
    .in_ready (ray_ready),
    .in_data  (ray),
    .out_valid(prod_valid),
    .out_ready(prod_ready),
    .out_data (prod)
  );

  bpj_accum_stage u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (prod_valid),
    .in_ready (prod_ready),
    .in_data  (prod),
    .out_valid(acc_valid),
    .out_ready(acc_ready),
    .out_data (acc)
  );

  bpj_sat_stage u_sat (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (acc_valid),
    .in_ready (acc_ready),
    .in_data  (acc),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (pt)
  );

  assign out_point_x     = pt.x;
  assign out_point_y     = pt.y;
  assign out_point_z     = pt.z;
  assign out_point_valid = pt.valid;

  // skipped points carry zero coordinates
  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_point_valid) |->
      (out_point_x == '0 && out_point_y == '0 && out_point_z == '0))
    else $error("skipped point with nonzero coordinates");

  // input stalls only when every stage is full and the output is blocked
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && ray_valid && prod_valid && acc_valid))
    else $error("input stalled with a bubble in the pipeline");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> (!out_valid && !ray_valid && !prod_valid && !acc_valid))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// File: tb/tb.sv
// tb: self-checking bench for depth_pixel_backprojection_core, with random traffic
// on both valid/ready channels and a matrix predictor checking every point
// depends on bpj_pkg and depth_pixel_backprojection_core
`default_nettype none

module tb;
  import bpj_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PRINT_CAP   = 40;
  localparam longint ONE_Q24 = 64'sd16777216;

  // expected points and the matrix/range copy that produces them
  class backprojection_checker;
    cfg_t   cfg;
    point_t expected_points[$];
    int     mismatches;
    int     points_seen;

    function new();
      cfg.k00      = 32'(ONE_Q24);
      cfg.k01      = '0;
      cfg.k02      = '0;
      cfg.k11      = 32'(ONE_Q24);
      cfg.k12      = '0;
      cfg.k22      = 32'(ONE_Q24);
      cfg.depth_lo = '0;
      cfg.depth_hi = '1;
      mismatches   = 0;
      points_seen  = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [COEF_W-1:0] v);
      case (idx)
        REG_INV_K_00:  cfg.k00 = v;
        REG_INV_K_01:  cfg.k01 = v;
        REG_INV_K_02:  cfg.k02 = v;
        REG_INV_K_11:  cfg.k11 = v;
        REG_INV_K_12:  cfg.k12 = v;
        REG_INV_K_22:  cfg.k22 = v;
        REG_MIN_DEPTH: cfg.depth_lo = v[DEPTH_W-1:0];
        REG_MAX_DEPTH: cfg.depth_hi = v[DEPTH_W-1:0];
        default: ;
      endcase
    endfunction

    // q24 to millimetres: round half up, then clamp to 24-bit signed
    function logic signed [OUT_W-1:0] round_sat(longint acc);
      longint q;
      q = (acc + 64'sd8388608) >>> FRAC_BITS;
      if (q > 64'sd8388607) q = 64'sd8388607;
      if (q < -64'sd8388608) q = -64'sd8388608;
      return q[OUT_W-1:0];
    endfunction

    // pinhole back-projection of one pixel through the upper-triangular inverse
    function point_t project_pixel(pix_t p);
      point_t r;
      longint cd, rd, dd;
      r = '0;
      if (!p.present || p.d < cfg.depth_lo || p.d > cfg.depth_hi ||
          p.row >= MAX_DIMENSION_DEF || p.col >= MAX_DIMENSION_DEF)
        return r;
      cd = longint'(p.col) * longint'(p.d);
      rd = longint'(p.row) * longint'(p.d);
      dd = longint'(p.d);
      r.x = round_sat(longint'(cfg.k00) * cd + longint'(cfg.k01) * rd +
                      longint'(cfg.k02) * dd);
      r.y = round_sat(longint'(cfg.k11) * rd + longint'(cfg.k12) * dd);
      r.z = round_sat(longint'(cfg.k22) * dd);
      r.valid = 1'b1;
      return r;
    endfunction

    function void note_pixel(pix_t p);
      expected_points = {expected_points, project_pixel(p)};
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    task flag_mismatch(string msg);
      if (mismatches < PRINT_CAP)
        $display("mismatch at point %0d: %s", points_seen, msg);
      mismatches++;
    endtask

    task check_point(point_t got);
      point_t want;
      if (expected_points.size() == 0) begin
        flag_mismatch($sformatf("unexpected transfer x=%0d y=%0d z=%0d valid=%0b",
                                got.x, got.y, got.z, got.valid));
        points_seen++;
        return;
      end
      want = expected_points.pop_front();
      if (got.x !== want.x)
        flag_mismatch($sformatf("point_x %0d, want %0d", got.x, want.x));
      if (got.y !== want.y)
        flag_mismatch($sformatf("point_y %0d, want %0d", got.y, want.y));
      if (got.z !== want.z)
        flag_mismatch($sformatf("point_z %0d, want %0d", got.z, want.z));
      if (got.valid !== want.valid)
        flag_mismatch($sformatf("point_valid %0b, want %0b", got.valid, want.valid));
      points_seen++;
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  cfg_reg_t             cfg_index = REG_INV_K_00;
  logic [COEF_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [IDX_W-1:0]     in_pixel_row = '0;
  logic [IDX_W-1:0]     in_pixel_col = '0;
  logic [DEPTH_W-1:0]   in_depth_mm = '0;
  logic                 in_depth_present = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_point_x;
  logic signed [OUT_W-1:0] out_point_y;
  logic signed [OUT_W-1:0] out_point_z;
  logic                 out_point_valid;

  backprojection_checker chk = new();
  int cycles = 0;

  depth_pixel_backprojection_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_row     (in_pixel_row),
    .in_pixel_col     (in_pixel_col),
    .in_depth_mm      (in_depth_mm),
    .in_depth_present (in_depth_present),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_point_z      (out_point_z),
    .out_point_valid  (out_point_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[depth_pixel_backprojection_core] ERROR");
      $finish;
    end
  end

  // result side: check each transfer, stall on a changing pattern
  int       stall_mode = 0;
  int       mode_left = 0;
  int       tick = 0;
  logic [7:0] stall_pattern = 8'hff;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      chk.check_point({out_point_x, out_point_y, out_point_z, out_point_valid});
    if (mode_left == 0) begin
      stall_mode    = $urandom_range(0, 4);
      mode_left     = $urandom_range(32, 256);
      stall_pattern = 8'($urandom) | 8'h01;
    end else begin
      mode_left--;
    end
    tick++;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 9) != 0);
      3: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= stall_pattern[tick % 8];
    endcase
  end

  function automatic pix_t pixel_at(int unsigned row, int unsigned col,
                                    int unsigned d, bit present);
    pix_t p;
    p.row     = row[IDX_W-1:0];
    p.col     = col[IDX_W-1:0];
    p.d       = d[DEPTH_W-1:0];
    p.present = present;
    return p;
  endfunction

  function automatic cfg_t matrix_cfg(logic [31:0] k00, logic [31:0] k01,
                                      logic [31:0] k02, logic [31:0] k11,
                                      logic [31:0] k12, logic [31:0] k22,
                                      logic [15:0] lo, logic [15:0] hi);
    cfg_t c;
    c.k00 = k00;
    c.k01 = k01;
    c.k02 = k02;
    c.k11 = k11;
    c.k12 = k12;
    c.k22 = k22;
    c.depth_lo = lo;
    c.depth_hi = hi;
    return c;
  endfunction

  // signed coefficient within +-span, sometimes any 32-bit value
  function automatic logic [31:0] rand_coef(int unsigned span);
    logic [31:0] v;
    if ($urandom_range(0, 4) == 0)
      return $urandom;
    v = $urandom_range(0, span);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic cfg_t random_cfg();
    logic [15:0] lo, hi;
    if ($urandom_range(0, 9) == 0) begin
      lo = 16'($urandom);
      hi = 16'($urandom);
    end else begin
      lo = 16'($urandom_range(0, 20000));
      hi = 16'(32'(lo) + $urandom_range(0, 45535));
    end
    return matrix_cfg(rand_coef(1 << 21), rand_coef(1 << 16), rand_coef(1 << 28),
                      rand_coef(1 << 21), rand_coef(1 << 28), rand_coef(1 << 28),
                      lo, hi);
  endfunction

  // mostly in-range depths for the current window, plus misses and edges
  function automatic pix_t random_pixel();
    pix_t p;
    int unsigned pick;
    logic [15:0] lo, hi;
    lo   = chk.cfg.depth_lo;
    hi   = chk.cfg.depth_hi;
    pick = $urandom_range(0, 99);
    p.row = IDX_W'($urandom);
    p.col = IDX_W'($urandom);
    if ($urandom_range(0, 9) == 0) p.row = $urandom_range(0, 1) ? '1 : '0;
    if ($urandom_range(0, 9) == 0) p.col = $urandom_range(0, 1) ? '1 : '0;
    p.present = (pick >= 8);
    if (pick < 18 || lo > hi) begin
      p.d = DEPTH_W'($urandom);
    end else if (pick < 28) begin
      case ($urandom_range(0, 3))
        0: p.d = lo;
        1: p.d = hi;
        2: p.d = lo - 1'b1;
        default: p.d = hi + 1'b1;
      endcase
    end else begin
      p.d = DEPTH_W'($urandom_range(lo, hi));
    end
    return p;
  endfunction

  // one input transfer; valid stays up until accepted
  task automatic send_pixel(input pix_t p);
    in_valid         <= 1'b1;
    in_pixel_row     <= p.row;
    in_pixel_col     <= p.col;
    in_depth_mm      <= p.d;
    in_depth_present <= p.present;
    do @(posedge clk); while (!in_ready);
    chk.note_pixel(p);
  endtask

  task automatic idle_gap(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // hold the sender until every expected point has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk.pending() != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [COEF_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    chk.set_reg(idx, v);
  endtask

  task automatic load_config(input cfg_t c);
    drain();
    write_reg(REG_INV_K_00, c.k00);
    write_reg(REG_INV_K_01, c.k01);
    write_reg(REG_INV_K_02, c.k02);
    write_reg(REG_INV_K_11, c.k11);
    write_reg(REG_INV_K_12, c.k12);
    write_reg(REG_INV_K_22, c.k22);
    write_reg(REG_MIN_DEPTH, {16'h0, c.depth_lo});
    write_reg(REG_MAX_DEPTH, {16'h0, c.depth_hi});
    cfg_we <= 1'b0;
  endtask

  // bursts with random gaps, and a full drain halfway through
  task automatic send_random(input int count);
    int burst;
    int unsigned gap;
    burst = $urandom_range(1, 64);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        drain();
      end else if (burst <= 0) begin
        gap = $urandom_range(0, 12);
        if (gap != 0) idle_gap(gap);
        burst = $urandom_range(1, 64);
      end
      send_pixel(random_pixel());
      burst--;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset matrix: identity, full depth window
    send_pixel(pixel_at(0, 0, 0, 1));
    send_pixel(pixel_at(4095, 4095, 65535, 1));
    send_pixel(pixel_at(0, 4095, 65535, 1));
    send_pixel(pixel_at(4095, 0, 65535, 1));
    send_pixel(pixel_at(0, 0, 65535, 1));
    send_pixel(pixel_at(1, 1, 1, 1));
    send_pixel(pixel_at(0, 0, 0, 0));
    send_pixel(pixel_at(4095, 4095, 65535, 0));
    send_pixel(pixel_at(100, 200, 3000, 1));
    send_random(100);

    // typical camera, 200..10000 mm window
    load_config(matrix_cfg(33554, 0, -10737418, 33554, -8053064, 32'(ONE_Q24),
                           16'd200, 16'd10000));
    send_pixel(pixel_at(240, 320, 199, 1));
    send_pixel(pixel_at(240, 320, 200, 1));
    send_pixel(pixel_at(240, 320, 10000, 1));
    send_pixel(pixel_at(240, 320, 10001, 1));
    send_pixel(pixel_at(240, 320, 500, 0));
    send_pixel(pixel_at(479, 639, 1000, 1));
    send_random(300);

    // all coefficients at the positive extreme
    load_config(matrix_cfg(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           32'h7fffffff, 32'h7fffffff, 16'd0, 16'd65535));
    send_random(150);

    // all coefficients at the negative extreme
    load_config(matrix_cfg(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                           32'h80000000, 32'h80000000, 16'd0, 16'd65535));
    send_pixel(pixel_at(4095, 4095, 65535, 1));
    send_pixel(pixel_at(0, 0, 1, 1));
    send_random(150);

    // half-unit coefficients for rounding ties, single-depth window
    load_config(matrix_cfg(32'h00800000, 0, 32'hff800000, 32'hff800000, 0,
                           32'h00800000, 16'd1, 16'd1));
    send_pixel(pixel_at(1, 1, 1, 1));
    send_pixel(pixel_at(1, 2, 1, 1));
    send_pixel(pixel_at(3, 5, 1, 1));
    send_pixel(pixel_at(1, 1, 0, 1));
    send_pixel(pixel_at(1, 1, 2, 1));
    send_random(60);

    // inverted window: nothing is valid
    load_config(matrix_cfg(32'(ONE_Q24), 0, 0, 32'(ONE_Q24), 0, 32'(ONE_Q24),
                           16'd65535, 16'd0));
    send_pixel(pixel_at(10, 10, 0, 1));
    send_pixel(pixel_at(10, 10, 65535, 1));
    send_pixel(pixel_at(10, 10, 30000, 1));
    send_random(60);

    // random matrices and windows
    for (int n = 0; n < 5; n++) begin
      load_config(random_cfg());
      send_random(180);
    end

    drain();
    repeat (8) @(posedge clk);
    if (chk.mismatches == 0 && chk.pending() == 0)
      $display("[depth_pixel_backprojection_core] OK");
    else
      $display("[depth_pixel_backprojection_core] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
